FILE: hw/rtl/feal4_block_cipher_core_assert.svh
// Assertion macros for the FEAL-4 core.
// Each check is clocked on clk and is off while rst_n is low.
`ifndef FEAL4_BLOCK_CIPHER_CORE_ASSERT_SVH
`define FEAL4_BLOCK_CIPHER_CORE_ASSERT_SVH

// Clocked implication; the consequent may be a delayed sequence
`define FEAL4_PROP(ante, cons) \
  @(posedge clk) disable iff (!rst_n) (ante) |-> cons

// Labeled assertion that reports through $error
`define FEAL4_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (`FEAL4_PROP(ante, cons)) else $error(msg);

`endif

FILE: hw/rtl/feal4_pkg.sv
package feal4_pkg;

  localparam int unsigned HALF_W   = 32;
  localparam int unsigned BLOCK_W  = 64;
  localparam int unsigned ROUNDS   = 4;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SUBKEY_0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBKEY_1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBKEY_2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBKEY_3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITEN_LEFT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITEN_RIGHT = 3'd5;

  // Full key set as held by the register file
  typedef struct packed {
    logic [ROUNDS-1:0][HALF_W-1:0] subkey;
    logic [HALF_W-1:0]             whiten_l;
    logic [HALF_W-1:0]             whiten_r;
  } key_set_t;

  // One pipeline slot: a is the half fed to F, b the other half
  typedef struct packed {
    logic              valid;
    logic              dec;
    logic [HALF_W-1:0] a;
    logic [HALF_W-1:0] b;
  } stage_t;

  // Rotate a byte left by two
  function automatic logic [7:0] rot2(logic [7:0] v);
    return {v[5:0], v[7:6]};
  endfunction

  // FEAL round function, byte 0 most significant; sums wrap at 8 bits
  function automatic logic [HALF_W-1:0] round_fn(logic [HALF_W-1:0] w);
    logic [7:0] x0, x1, x2, x3, d01, d23, y0, y1, y2, y3;
    x0  = w[31:24];
    x1  = w[23:16];
    x2  = w[15:8];
    x3  = w[7:0];
    d01 = x0 ^ x1;
    d23 = x2 ^ x3;
    y1  = rot2(d01 + d23 + 8'd1);
    y0  = rot2(x0 + y1);
    y2  = rot2(y1 + d23);
    y3  = rot2(y2 + x3 + 8'd1);
    return {y0, y1, y2, y3};
  endfunction

endpackage

FILE: hw/rtl/feal4_key_regs.sv
module feal4_key_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [feal4_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [feal4_pkg::HALF_W-1:0]    wr_data,
  output feal4_pkg::key_set_t            keys
);
  import feal4_pkg::*;

  key_set_t keys_r, keys_nxt;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    keys_nxt = keys_r;
    if (wr_en) begin
      case (wr_index)
        CFG_SUBKEY_0:     keys_nxt.subkey[0] = wr_data;
        CFG_SUBKEY_1:     keys_nxt.subkey[1] = wr_data;
        CFG_SUBKEY_2:     keys_nxt.subkey[2] = wr_data;
        CFG_SUBKEY_3:     keys_nxt.subkey[3] = wr_data;
        CFG_WHITEN_LEFT:  keys_nxt.whiten_l  = wr_data;
        CFG_WHITEN_RIGHT: keys_nxt.whiten_r  = wr_data;
        default:          keys_nxt = keys_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= '0;
    end else begin
      keys_r <= keys_nxt;
    end
  end

  assign keys = keys_r;

endmodule

FILE: hw/rtl/feal4_round.sv
module feal4_round (
  input  logic                        clk,
  input  logic                        rst_n,
  input  feal4_pkg::stage_t           stage_in,
  input  logic [feal4_pkg::HALF_W-1:0] enc_key,
  input  logic [feal4_pkg::HALF_W-1:0] dec_key,
  output feal4_pkg::stage_t           stage_out
);
  import feal4_pkg::*;

  stage_t stage_r, stage_nxt;
  logic [HALF_W-1:0] rkey;

  // One Feistel round; the key order depends on direction
  always_comb begin
    rkey            = stage_in.dec ? dec_key : enc_key;
    stage_nxt.valid = stage_in.valid;
    stage_nxt.dec   = stage_in.dec;
    stage_nxt.a     = stage_in.b ^ round_fn(stage_in.a ^ rkey);
    stage_nxt.b     = stage_in.a;
  end

  // Only the valid bit needs reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.dec <= stage_nxt.dec;
    stage_r.a   <= stage_nxt.a;
    stage_r.b   <= stage_nxt.b;
  end

  assign stage_out = stage_r;

endmodule

FILE: hw/rtl/feal4_block_cipher_core.sv
// FEAL-4 encrypt/decrypt core, six-subkey form. Raise start with in_req_type
// (0 encrypt, 1 decrypt) and in_block_in; the item is taken at any clock edge
// where busy is low, which is every cycle out of reset, so one block per cycle
// is sustained. Each result appears on out_block_out, marked by a one-cycle
// out_valid strobe, after passing one whitening stage, one stage per Feistel
// round (four) and an output stage. There is no backpressure from the result
// side, so results must be captured on the cycle they are shown. Keys are
// written through the cfg port (indexes 0-3 round subkeys, 4 and 5 whitening
// words; other indexes are ignored) and must only be changed while no item is
// in flight.
module feal4_block_cipher_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_req_type,
  input  logic [feal4_pkg::BLOCK_W-1:0]   in_block_in,
  output logic                            out_valid,
  output logic [feal4_pkg::BLOCK_W-1:0]   out_block_out,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [feal4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [feal4_pkg::HALF_W-1:0]    cfg_data
);
  import feal4_pkg::*;

  key_set_t keys;
  stage_t   init_r, init_nxt;
  stage_t   rnd [0:ROUNDS];
  logic     in_accept;
  logic     out_valid_r;
  logic [BLOCK_W-1:0] out_block_r, out_block_nxt;
  logic [HALF_W-1:0]  hi, lo;

  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;
  assign in_accept = start & ~busy;

  feal4_key_regs u_keys (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .keys     (keys)
  );

  // Input whitening: encrypt folds in keys 4/5, decrypt only mixes halves
  always_comb begin
    hi             = in_block_in[BLOCK_W-1:HALF_W];
    lo             = in_block_in[HALF_W-1:0];
    init_nxt.valid = in_accept;
    init_nxt.dec   = in_req_type;
    if (in_req_type) begin
      init_nxt.b = hi;
      init_nxt.a = hi ^ lo;
    end else begin
      init_nxt.b = hi ^ keys.whiten_l;
      init_nxt.a = hi ^ lo ^ keys.whiten_l ^ keys.whiten_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r.valid <= 1'b0;
    end else begin
      init_r.valid <= init_nxt.valid;
    end
    init_r.dec <= init_nxt.dec;
    init_r.a   <= init_nxt.a;
    init_r.b   <= init_nxt.b;
  end

  assign rnd[0] = init_r;

  // Four round stages; decrypt walks the subkeys backwards
  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    feal4_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_in  (rnd[g]),
      .enc_key   (keys.subkey[g]),
      .dec_key   (keys.subkey[ROUNDS-1-g]),
      .stage_out (rnd[g+1])
    );
  end

  // Output fold, plus unwhitening on decrypt
  always_comb begin
    if (rnd[ROUNDS].dec) begin
      out_block_nxt = {rnd[ROUNDS].a ^ keys.whiten_l,
                       rnd[ROUNDS].b ^ rnd[ROUNDS].a ^ keys.whiten_r};
    end else begin
      out_block_nxt = {rnd[ROUNDS].a, rnd[ROUNDS].b ^ rnd[ROUNDS].a};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rnd[ROUNDS].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_block_r <= out_block_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_block_out = out_block_r;

  // Every taken item comes out at the end of the pipeline, and nothing else does
  `include "feal4_block_cipher_core_assert.svh"
  `FEAL4_ASSERT(a_item_out_latency, in_accept, ##6 out_valid, "item lost in pipeline")
  `FEAL4_ASSERT(a_no_spurious_out, out_valid, $past(in_accept, 6), "result without item")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import feal4_pkg::*;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } cipher_op_e;

  // one input item: selector plus block
  typedef struct packed {
    cipher_op_e        op;
    logic [BLOCK_W-1:0] blk;
  } block_req_t;

  // indexes past the last key word; writes there must not land anywhere
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  localparam int NUM_PHASES     = 6;
  localparam int ITEMS_PER_PASS = 300;
  localparam int IDLE_PCT       = 19;
  localparam int DRAIN_CYCLES   = 10;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_req_type = 1'b0;
  logic [BLOCK_W-1:0]   in_block_in = '0;
  logic                 out_valid;
  logic [BLOCK_W-1:0]   out_block_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [HALF_W-1:0]    cfg_data = '0;

  feal4_block_cipher_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_block_in   (in_block_in),
    .out_valid     (out_valid),
    .out_block_out (out_block_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // key copy tracked from accepted register writes
  logic [ROUNDS-1:0][HALF_W-1:0] round_key;
  logic [HALF_W-1:0]             whiten_l;
  logic [HALF_W-1:0]             whiten_r;

  logic [BLOCK_W-1:0] block_out_q [$];

  int blocks_sent;
  int enc_sent;
  int dec_sent;
  int results_checked;
  int mismatch_count;
  int key_settings;
  bit idle_on;

  block_req_t directed_tbl [12] = '{
    '{OP_ENCRYPT, 64'h0000_0000_0000_0000},
    '{OP_DECRYPT, 64'h0000_0000_0000_0000},
    '{OP_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF},
    '{OP_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF},
    '{OP_ENCRYPT, 64'h8000_0000_0000_0000},
    '{OP_DECRYPT, 64'h0000_0000_0000_0001},
    '{OP_ENCRYPT, 64'h0000_0000_FFFF_FFFF},
    '{OP_DECRYPT, 64'hFFFF_FFFF_0000_0000},
    '{OP_ENCRYPT, 64'hAAAA_AAAA_5555_5555},
    '{OP_DECRYPT, 64'h5555_5555_AAAA_AAAA},
    '{OP_ENCRYPT, 64'h7F7F_7F7F_8080_8080},
    '{OP_DECRYPT, 64'h80FF_017F_00FF_7F01}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // byte rotate left by two
  function automatic logic [7:0] rotl2(input logic [7:0] v);
    logic [7:0] r;
    r = (v << 2) | (v >> 6);
    return r;
  endfunction

  // FEAL mixing function; byte sums wrap at 8 bits
  function automatic logic [HALF_W-1:0] feal_f(input logic [HALF_W-1:0] w);
    logic [7:0] b0, b1, b2, b3, o0, o1, o2, o3;
    b0 = w[31:24];
    b1 = w[23:16];
    b2 = w[15:8];
    b3 = w[7:0];
    o1 = rotl2((b0 ^ b1) + (b2 ^ b3) + 8'd1);
    o0 = rotl2(b0 + o1);
    o2 = rotl2(o1 + (b2 ^ b3));
    o3 = rotl2(o2 + b3 + 8'd1);
    return {o0, o1, o2, o3};
  endfunction

  // expected output block under the current key copy
  function automatic logic [BLOCK_W-1:0] feal4_crypt(input cipher_op_e op,
                                                     input logic [BLOCK_W-1:0] blk);
    logic [HALF_W-1:0] l, r, t;
    if (op == OP_ENCRYPT) begin
      l = blk[63:32] ^ whiten_l;
      r = l ^ blk[31:0] ^ whiten_r;
      for (int i = 0; i < ROUNDS; i++) begin
        t = r;
        r = l ^ feal_f(r ^ round_key[i]);
        l = t;
      end
      l ^= r;
      return {r, l};
    end else begin
      r = blk[63:32];
      l = r ^ blk[31:0];
      for (int i = 0; i < ROUNDS; i++) begin
        t = l;
        l = r ^ feal_f(l ^ round_key[ROUNDS-1-i]);
        r = t;
      end
      r ^= l;
      l ^= whiten_l;
      r ^= whiten_r;
      return {l, r};
    end
  endfunction

  // monitor: check results, then predict accepted items and track key writes
  always @(posedge clk) begin
    logic [BLOCK_W-1:0] exp_blk;
    if (!rst_n) begin
      round_key = '0;
      whiten_l  = '0;
      whiten_r  = '0;
      block_out_q.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (block_out_q.size() == 0) begin
          $error("result with no item outstanding: block_out %h", out_block_out);
          mismatch_count++;
        end else begin
          exp_blk = block_out_q.pop_front();
          results_checked++;
          if (out_block_out !== exp_blk) begin
            $error("block_out: expected %h, actual %h", exp_blk, out_block_out);
            mismatch_count++;
          end
        end
      end
      if (start && busy === 1'b0)
        block_out_q.push_back(feal4_crypt(cipher_op_e'(in_req_type), in_block_in));
      if (cfg_valid && cfg_ready === 1'b1) begin
        case (cfg_index)
          CFG_SUBKEY_0:     round_key[0] = cfg_data;
          CFG_SUBKEY_1:     round_key[1] = cfg_data;
          CFG_SUBKEY_2:     round_key[2] = cfg_data;
          CFG_SUBKEY_3:     round_key[3] = cfg_data;
          CFG_WHITEN_LEFT:  whiten_l = cfg_data;
          CFG_WHITEN_RIGHT: whiten_r = cfg_data;
          default: ;  // spare indexes are ignored
        endcase
      end
    end
  end

  // present one item and hold it until taken; start is left high
  task automatic send_block(input cipher_op_e op, input logic [BLOCK_W-1:0] blk);
    start       <= 1'b1;
    in_req_type <= op;
    in_block_in <= blk;
    do @(posedge clk); while (busy !== 1'b0);
    blocks_sent++;
    if (op == OP_ENCRYPT) enc_sent++;
    else dec_sent++;
  endtask

  // random idle cycles, each taken with IDLE_PCT odds; junk on the data ports
  task automatic idle_gap();
    if (idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        start       <= 1'b0;
        in_req_type <= 1'($urandom);
        in_block_in <= {$urandom, $urandom};
        @(posedge clk);
      end
    end
  endtask

  // stop sending and wait until every expected result has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (block_out_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write; cfg_valid is left high for back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // full key load; spare indexes last so any aliasing would corrupt a key
  task automatic load_keys(input logic [5:0][HALF_W-1:0] k);
    write_reg(CFG_SUBKEY_0, k[CFG_SUBKEY_0]);
    write_reg(CFG_SUBKEY_1, k[CFG_SUBKEY_1]);
    write_reg(CFG_SUBKEY_2, k[CFG_SUBKEY_2]);
    write_reg(CFG_SUBKEY_3, k[CFG_SUBKEY_3]);
    write_reg(CFG_WHITEN_LEFT, k[CFG_WHITEN_LEFT]);
    write_reg(CFG_WHITEN_RIGHT, k[CFG_WHITEN_RIGHT]);
    write_reg(CFG_SPARE_6, $urandom);
    write_reg(CFG_SPARE_7, $urandom);
    cfg_valid <= 1'b0;
    @(posedge clk);
    key_settings++;
  endtask

  task automatic run_directed();
    foreach (directed_tbl[i]) begin
      send_block(directed_tbl[i].op, directed_tbl[i].blk);
      idle_gap();
    end
  endtask

  // block built from corner bytes to stress the byte carries
  function automatic logic [BLOCK_W-1:0] corner_block();
    logic [BLOCK_W-1:0] b;
    logic [7:0] pick [5] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
    for (int i = 0; i < 8; i++)
      b[i*8 +: 8] = pick[$urandom_range(4)];
    return b;
  endfunction

  task automatic run_random(input int n_items);
    int sent;
    int sel;
    logic [BLOCK_W-1:0] plain;
    logic [BLOCK_W-1:0] ciph;
    bit paused;
    sent   = 0;
    paused = 0;
    while (sent < n_items) begin
      sel = $urandom_range(99);
      if (sel < 15) begin
        // round trip: encrypt, then decrypt the predicted ciphertext
        plain = {$urandom, $urandom};
        ciph  = feal4_crypt(OP_ENCRYPT, plain);
        send_block(OP_ENCRYPT, plain);
        idle_gap();
        send_block(OP_DECRYPT, ciph);
        sent += 2;
      end else if (sel < 30) begin
        send_block(cipher_op_e'($urandom_range(1)), corner_block());
        sent++;
      end else begin
        send_block(cipher_op_e'($urandom_range(1)), {$urandom, $urandom});
        sent++;
      end
      idle_gap();
      // sender hold-off until the pipe is empty
      if (!paused && sent >= n_items / 2) begin
        drain();
        paused = 1;
      end
    end
  endtask

  // stimulus
  initial begin
    logic [5:0][HALF_W-1:0] keys;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset keys are all zero
    idle_on = 1;
    run_directed();
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: keys = '1;
        1: keys = {32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h0000_0000,
                   32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};
        2: keys = '0;
        default: begin
          for (int i = 0; i < 6; i++) keys[i] = $urandom;
        end
      endcase
      load_keys(keys);
      // all-ones keys: directed rows again, then a long run with no idling
      idle_on = (p != 0);
      if (p == 0) run_directed();
      run_random(ITEMS_PER_PASS);
      drain();
    end

    $display("Sent %0d blocks (%0d encrypt, %0d decrypt) under %0d key loads plus reset keys",
             blocks_sent, enc_sent, dec_sent, key_settings);
    $display("Checked %0d results, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0 && block_out_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("Timeout: %0d results still outstanding", block_out_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
